/* rtl/csf_pkg.sv */
// ----------------------------------------------------------------------------
// Comment strip and space collapse filter package
// Character codes, state types and the whitespace stage step function of the
// filter, and the output queue geometry and push type shared with its queue.
// ----------------------------------------------------------------------------
package csf_pkg;

  // Character codes that the filter reacts to.
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;

  // Output queue geometry.
  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  // Comment stage states.
  typedef enum logic [5:0] {
    CM_NORMAL     = 6'b000001,
    CM_PAREN_SEEN = 6'b000010,
    CM_SLASH_SEEN = 6'b000100,
    CM_BLOCK      = 6'b001000,
    CM_BLOCK_STAR = 6'b010000,
    CM_LINE       = 6'b100000
  } cm_state_t;

  // Whitespace stage states.
  typedef enum logic [2:0] {
    SM_NORMAL = 3'b001,
    SM_SKIP   = 3'b010,
    SM_QUOTED = 3'b100
  } sm_state_t;

  // Result of feeding one byte to the whitespace stage.
  typedef struct packed {
    logic      emit;
    logic [7:0] ch;
    sm_state_t mode;
  } sm_step_t;

  // Bytes produced by one accepted item, in stream order.
  typedef struct packed {
    logic [1:0] num;
    logic [7:0] ch0;
    logic [7:0] ch1;
  } oq_push_t;

  function automatic logic is_blank(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL);
  endfunction

  // One step of the whitespace collapse machine.
  function automatic sm_step_t space_step(sm_state_t mode, logic [7:0] c);
    sm_step_t r;
    r.emit = 1'b1;
    r.ch   = c;
    r.mode = SM_NORMAL;
    unique case (mode)
      SM_SKIP: begin
        if (is_blank(c)) begin
          r.emit = 1'b0;
          r.mode = SM_SKIP;
        end else if (c == CH_QUOTE) begin
          r.mode = SM_QUOTED;
        end
      end
      SM_QUOTED: begin
        r.mode = (c == CH_QUOTE) ? SM_NORMAL : SM_QUOTED;
      end
      default: begin
        if (c == CH_QUOTE) begin
          r.mode = SM_QUOTED;
        end else if (is_blank(c)) begin
          r.mode = SM_SKIP;
          r.ch   = CH_SPACE;
        end
      end
    endcase
    return r;
  endfunction

endpackage

/* rtl/csf_if.sv */
// ----------------------------------------------------------------------------
// Filter byte channels
// Valid/ready channels for the raw input bytes and the filtered output bytes.
// ----------------------------------------------------------------------------
interface csf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

interface csf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;

  modport source (output valid, output char_out, input ready);
  modport sink   (input valid, input char_out, output ready);
endinterface

/* rtl/csf_out_fifo.sv */
// ----------------------------------------------------------------------------
// Filter output queue
// Small queue: takes zero, one or two bytes per cycle, hands out one on ready.
// ----------------------------------------------------------------------------
module csf_out_fifo
  import csf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  oq_push_t         push,
  output logic             room,
  csf_out_if.source        out_if
);

  logic [7:0]          mem_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_ptr_r;
  logic [OQ_PTR_W-1:0] rd_ptr_r;
  logic [OQ_CNT_W-1:0] cnt_r;
  logic [OQ_CNT_W-1:0] cnt_nxt;
  logic                pop;

  // Output side and free space for a full two-byte push.
  assign out_if.valid    = (cnt_r != '0);
  assign out_if.char_out = mem_r[rd_ptr_r];
  assign pop             = out_if.valid & out_if.ready;
  assign room            = (cnt_r <= OQ_CNT_W'(OQ_DEPTH - 2));
  assign cnt_nxt         = cnt_r + OQ_CNT_W'(push.num) - OQ_CNT_W'(pop);

  // Storage writes, first byte then second byte.
  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem_r[wr_ptr_r] <= push.ch0;
    end
    if (push.num == 2'd2) begin
      mem_r[wr_ptr_r + OQ_PTR_W'(1)] <= push.ch1;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + OQ_PTR_W'(push.num);
      rd_ptr_r <= rd_ptr_r + OQ_PTR_W'(pop);
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

/* rtl/comment_strip_space_collapse_filter_unit.sv */
// ----------------------------------------------------------------------------
// Comment strip and space collapse filter
// Drops (* *) and // comments from a byte stream and collapses whitespace
// runs outside quoted strings into one space.
// ----------------------------------------------------------------------------
//  Channel   Direction   Payload          Accepted when
//  in_if     sink        char_in  [7:0]   valid && ready
//  out_if    source      char_out [7:0]   valid && ready
//
//  When an item is taken, both state machines advance at that clock edge
//  and its zero, one or two bytes enter a four-entry output queue.
//  The output port drains one byte per cycle while out_if.ready is high, so
//  the sustained rate is one item per cycle for single-byte items.
//  in_if.ready is high while the queue has room for two bytes.
//  Reset (synchronous, rst_n low) empties the queue and returns both state
//  machines to normal mode; a stalled output only holds off new items.
// ----------------------------------------------------------------------------
module comment_strip_space_collapse_filter_unit
  import csf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  csf_in_if.sink    in_if,
  csf_out_if.source out_if
);

  cm_state_t  cm_r;
  cm_state_t  cm_nxt;
  sm_state_t  sm_r;
  sm_state_t  sm_nxt;
  sm_state_t  sm_mid;
  logic       accept;
  logic       room;
  logic [7:0] c;
  logic       b0_v;
  logic       b1_v;
  logic [7:0] b0;
  logic [7:0] b1;
  sm_step_t   s1;
  sm_step_t   s2;
  logic       e0;
  logic       e1;
  oq_push_t   push;

  assign in_if.ready = room;
  assign accept      = in_if.valid & room;
  assign c           = in_if.char_in;

  // Comment stage: picks up to two bytes to pass on.
  always_comb begin
    cm_nxt = cm_r;
    b0_v   = 1'b0;
    b1_v   = 1'b0;
    b0     = c;
    b1     = c;
    unique case (cm_r)
      CM_PAREN_SEEN: begin
        if (c == CH_STAR) begin
          cm_nxt = CM_BLOCK;
        end else begin
          cm_nxt = CM_NORMAL;
          b0_v   = 1'b1;
          b0     = CH_LPAREN;
          b1_v   = 1'b1;
        end
      end
      CM_SLASH_SEEN: begin
        if (c == CH_SLASH) begin
          cm_nxt = CM_LINE;
        end else begin
          cm_nxt = CM_NORMAL;
          b0_v   = 1'b1;
          b0     = CH_SLASH;
          b1_v   = 1'b1;
        end
      end
      CM_BLOCK: begin
        if (c == CH_STAR) begin
          cm_nxt = CM_BLOCK_STAR;
        end
      end
      CM_BLOCK_STAR: begin
        if (c == CH_RPAREN) begin
          cm_nxt = CM_NORMAL;
        end else if (c != CH_STAR) begin
          cm_nxt = CM_BLOCK;
        end
      end
      CM_LINE: begin
        if (c == CH_NL) begin
          cm_nxt = CM_NORMAL;
          b0_v   = 1'b1;
        end
      end
      default: begin
        if (c == CH_LPAREN) begin
          cm_nxt = CM_PAREN_SEEN;
        end else if (c == CH_SLASH) begin
          cm_nxt = CM_SLASH_SEEN;
        end else begin
          cm_nxt = CM_NORMAL;
          b0_v   = 1'b1;
        end
      end
    endcase
  end

  // Whitespace stage, applied to each passed byte in order.
  always_comb begin
    s1     = space_step(sm_r, b0);
    sm_mid = b0_v ? s1.mode : sm_r;
    s2     = space_step(sm_mid, b1);
    sm_nxt = b1_v ? s2.mode : sm_mid;
    e0     = accept & b0_v & s1.emit;
    e1     = accept & b1_v & s2.emit;
  end

  // Compact the emitted bytes for the queue.
  always_comb begin
    push.num = {1'b0, e0} + {1'b0, e1};
    push.ch0 = e0 ? s1.ch : s2.ch;
    push.ch1 = s2.ch;
  end

  // State registers advance on each accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cm_r <= CM_NORMAL;
      sm_r <= SM_NORMAL;
    end else if (accept) begin
      cm_r <= cm_nxt;
      sm_r <= sm_nxt;
    end
  end

  csf_out_fifo u_out_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .room   (room),
    .out_if (out_if)
  );

endmodule
